[src/srt_pkg.sv]
`default_nettype none

package srt_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    localparam int ID_W    = 16;
    localparam int KIND_W  = 10;
    localparam int COLOR_W = 10;
    localparam int WHEEL_W = 7;
    localparam int OWNER_W = 16;
    localparam int SLOT_W  = 4;
    localparam int OCC_W   = 5;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_DELETE = 1'b1
    } t_func;

    typedef struct packed {
        logic [ID_W-1:0]    item_id;
        logic [KIND_W-1:0]  kind_code;
        logic [COLOR_W-1:0] color_code;
        logic [WHEEL_W-1:0] wheel_half_units;
        logic [OWNER_W-1:0] owner_id;
    } t_rec;

    // what one cell shows its neighbors
    typedef struct packed {
        logic valid;
        t_rec rec;
        logic ins;   // new record lands at or before this cell
        logic del;   // first id match is at or before this cell
    } t_link;

endpackage

`default_nettype wire

[src/srt_cell.sv]
`default_nettype none

module srt_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_ins_en,
    input  wire logic          i_del_en,
    input  wire srt_pkg::t_rec i_new_rec,
    input  wire logic [srt_pkg::ID_W-1:0] i_del_id,
    input  wire srt_pkg::t_link i_prev,
    input  wire srt_pkg::t_link i_next,
    output srt_pkg::t_link      o_link
);
    import srt_pkg::*;

    logic r_valid;
    t_rec r_rec;
    logic n_valid;
    t_rec n_rec;
    logic gt;
    logic ins;
    logic del;
    logic match;

    always_comb begin
        gt = ({i_new_rec.kind_code, i_new_rec.wheel_half_units} <
              {r_rec.kind_code, r_rec.wheel_half_units});
        ins = !r_valid || gt;
        match = r_valid && (r_rec.item_id == i_del_id);
        del = i_prev.del || match;

        n_valid = r_valid;
        n_rec   = r_rec;
        if (i_ins_en && ins) begin
            if (i_prev.ins) begin
                n_valid = i_prev.valid;
                n_rec   = i_prev.rec;
            end else begin
                n_valid = 1'b1;
                n_rec   = i_new_rec;
            end
        end else if (i_del_en && del) begin
            n_valid = i_next.valid;
            n_rec   = i_next.rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_link = '{valid: r_valid, rec: r_rec, ins: ins, del: del};

endmodule

`default_nettype wire

[src/sorted_record_table.sv]
// Sorted record table, held in a row of cells sorted by kind code, then wheel size.
// Input channel: i_in_valid / o_in_stall carry one operation beat: i_func selects
// insert or delete-by-id, the other fields carry the record or the id to remove.
// Output channel: o_out_valid / i_out_stall carry one result beat per operation:
// success flag, slot placed or removed, and the occupied count afterward.
// Every cell compares the incoming key or id against its own entry and shifts
// from its neighbor in the same cycle, so the table updates on acceptance.
// The result beat is registered and appears in the cycle after acceptance.
// Throughput: one operation per cycle while the output side is not stalled.
// When the receiver stalls, the pending result holds and o_in_stall rises, so
// no further operation is taken until the result beat is delivered.
// Reset (synchronous, active low): all slots empty, count zero, no result pending.
// A full-table insert or an unknown id returns success 0, slot 0, count unchanged.
`default_nettype none

module sorted_record_table (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic                         i_func,
    input  wire logic [srt_pkg::ID_W-1:0]     i_item_id,
    input  wire logic [srt_pkg::KIND_W-1:0]   i_kind_code,
    input  wire logic [srt_pkg::COLOR_W-1:0]  i_color_code,
    input  wire logic [srt_pkg::WHEEL_W-1:0]  i_wheel_half_units,
    input  wire logic [srt_pkg::OWNER_W-1:0]  i_owner_id,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic                              o_success,
    output logic [srt_pkg::SLOT_W-1:0]        o_slot,
    output logic [srt_pkg::OCC_W-1:0]         o_occupied_count
);
    import srt_pkg::*;

    t_link links [DEPTH];
    t_link prev_link [DEPTH];
    t_link next_link [DEPTH];
    t_rec  new_rec;

    logic             in_acc;
    logic             full;
    logic             ins_en;
    logic             del_en;
    logic             found;
    logic [IDX_W-1:0] ins_idx;
    logic [IDX_W-1:0] del_idx;
    logic [31:0]      slot_ext;
    logic [31:0]      cnt_ext;

    logic             r_out_valid;
    logic             r_success;
    logic [SLOT_W-1:0] r_slot;
    logic [OCC_W-1:0] r_occ;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             n_success;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign full       = (r_count == CNT_W'(DEPTH));
    assign ins_en     = in_acc && (t_func'(i_func) == FUNC_INSERT) && !full;
    assign del_en     = in_acc && (t_func'(i_func) == FUNC_DELETE);
    assign found      = links[DEPTH-1].del;

    assign new_rec = '{item_id: i_item_id, kind_code: i_kind_code,
                       color_code: i_color_code,
                       wheel_half_units: i_wheel_half_units, owner_id: i_owner_id};

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            if (i == 0) begin
                prev_link[i] = '0;
            end else begin
                prev_link[i] = links[i-1];
            end
            if (i == DEPTH - 1) begin
                next_link[i] = '0;
            end else begin
                next_link[i] = links[i+1];
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        srt_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ins_en  (ins_en),
            .i_del_en  (del_en),
            .i_new_rec (new_rec),
            .i_del_id  (i_item_id),
            .i_prev    (prev_link[g]),
            .i_next    (next_link[g]),
            .o_link    (links[g])
        );
    end

    // first cell of each thermometer gives the slot
    always_comb begin
        ins_idx = '0;
        del_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (links[i].ins && !prev_link[i].ins) begin
                ins_idx = ins_idx | IDX_W'(i);
            end
            if (links[i].del && !prev_link[i].del) begin
                del_idx = del_idx | IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_count   = r_count;
        n_success = 1'b0;
        slot_ext  = '0;
        if (t_func'(i_func) == FUNC_INSERT) begin
            if (!full) begin
                n_count   = r_count + CNT_W'(1);
                n_success = 1'b1;
                slot_ext  = 32'(ins_idx);
            end
        end else if (found) begin
            n_count   = r_count - CNT_W'(1);
            n_success = 1'b1;
            slot_ext  = 32'(del_idx);
        end
        cnt_ext = 32'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (in_acc) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_success <= n_success;
            r_slot    <= slot_ext[SLOT_W-1:0];
            r_occ     <= cnt_ext[OCC_W-1:0];
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_success        = r_success;
    assign o_slot           = r_slot;
    assign o_occupied_count = r_occ;

endmodule

`default_nettype wire

[tb/tb_top.sv]
`default_nettype none

module tb_top;

    import srt_pkg::*;

    typedef struct packed {
        logic               success;
        logic [SLOT_W-1:0]  slot;
        logic [OCC_W-1:0]   occ;
    } t_outcome;

    typedef struct packed {
        t_func f;
        t_rec  r;
    } t_op;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic                i_func = 1'b0;
    logic [ID_W-1:0]     i_item_id = '0;
    logic [KIND_W-1:0]   i_kind_code = '0;
    logic [COLOR_W-1:0]  i_color_code = '0;
    logic [WHEEL_W-1:0]  i_wheel_half_units = '0;
    logic [OWNER_W-1:0]  i_owner_id = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic                o_success;
    logic [SLOT_W-1:0]   o_slot;
    logic [OCC_W-1:0]    o_occupied_count;

    t_op         pending_ops[$];
    t_outcome    outcome_q[$];
    t_rec        shadow_rec[DEPTH];
    int unsigned shadow_fill = 0;
    int          n_accepted = 0;
    int          err_cnt = 0;
    int          hold_cnt = 0;
    int          holds_done = 0;

    sorted_record_table i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_func             (i_func),
        .i_item_id          (i_item_id),
        .i_kind_code        (i_kind_code),
        .i_color_code       (i_color_code),
        .i_wheel_half_units (i_wheel_half_units),
        .i_owner_id         (i_owner_id),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_success          (o_success),
        .o_slot             (o_slot),
        .o_occupied_count   (o_occupied_count)
    );

    always #5 i_clk = ~i_clk;

    function automatic int sender_gap_pct();
        case ((n_accepted / 100) % 4)
            1: return 45;
            3: return 22;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case ((n_accepted / 100) % 4)
            2: return 45;
            3: return 22;
            default: return 0;
        endcase
    endfunction

    // sorted by (kind, wheel); new record goes after all equal keys
    function automatic t_outcome predict_outcome(t_func f, t_rec r);
        t_outcome o;
        int       pos;
        o = '0;
        pos = -1;
        if (f == FUNC_INSERT) begin
            if (shadow_fill < DEPTH) begin
                pos = shadow_fill;
                for (int i = 0; i < shadow_fill; i++) begin
                    if (pos == shadow_fill &&
                        (r.kind_code < shadow_rec[i].kind_code ||
                         (r.kind_code == shadow_rec[i].kind_code &&
                          r.wheel_half_units < shadow_rec[i].wheel_half_units))) begin
                        pos = i;
                    end
                end
                for (int i = shadow_fill; i > pos; i--) begin
                    shadow_rec[i] = shadow_rec[i-1];
                end
                shadow_rec[pos] = r;
                shadow_fill++;
            end
        end else begin
            for (int i = 0; i < shadow_fill; i++) begin
                if (pos < 0 && shadow_rec[i].item_id == r.item_id) begin
                    pos = i;
                end
            end
            if (pos >= 0) begin
                for (int u = pos; u + 1 < shadow_fill; u++) begin
                    shadow_rec[u] = shadow_rec[u+1];
                end
                shadow_fill--;
            end
        end
        o.success = (pos >= 0);
        o.slot    = (pos >= 0) ? pos[SLOT_W-1:0] : '0;
        o.occ     = shadow_fill[OCC_W-1:0];
        return o;
    endfunction

    task automatic push_op(t_func f, logic [ID_W-1:0] id, logic [KIND_W-1:0] kind,
                           logic [COLOR_W-1:0] color, logic [WHEEL_W-1:0] wheel,
                           logic [OWNER_W-1:0] owner);
        t_op op;
        op.f                  = f;
        op.r.item_id          = id;
        op.r.kind_code        = kind;
        op.r.color_code       = color;
        op.r.wheel_half_units = wheel;
        op.r.owner_id         = owner;
        pending_ops.push_back(op);
    endtask

    // driver
    always @(posedge i_clk) begin
        t_op  op;
        t_rec r;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r.item_id          = i_item_id;
                r.kind_code        = i_kind_code;
                r.color_code       = i_color_code;
                r.wheel_half_units = i_wheel_half_units;
                r.owner_id         = i_owner_id;
                outcome_q.push_back(predict_outcome(t_func'(i_func), r));
                n_accepted <= n_accepted + 1;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= sender_gap_pct()) begin
                    op = pending_ops.pop_front();
                    i_in_valid         <= 1'b1;
                    i_func             <= op.f;
                    i_item_id          <= op.r.item_id;
                    i_kind_code        <= op.r.kind_code;
                    i_color_code       <= op.r.color_code;
                    i_wheel_half_units <= op.r.wheel_half_units;
                    i_owner_id         <= op.r.owner_id;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the block backs up into its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt <= 0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (holds_done < 2 && n_accepted >= 400 * (holds_done + 1)) begin
            hold_cnt   <= 300;
            holds_done <= holds_done + 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (outcome_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected beat: success %0d slot %0d count %0d",
                                 o_success, o_slot, o_occupied_count);
                end else begin
                    want = outcome_q.pop_front();
                    if (o_success !== want.success || o_slot !== want.slot ||
                        o_occupied_count !== want.occ) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("mismatch: exp success %0d slot %0d count %0d, got %0d %0d %0d",
                                     want.success, want.slot, want.occ,
                                     o_success, o_slot, o_occupied_count);
                    end
                end
            end
            i_out_stall <= (hold_cnt != 0) || ($urandom_range(99) < receiver_stall_pct());
        end
    end

    initial begin
        int ins_pct;
        t_func f;
        logic [ID_W-1:0]    id;
        logic [KIND_W-1:0]  kind;
        logic [WHEEL_W-1:0] wheel;

        // directed: empty delete, extremes, fill past full, duplicate ids
        push_op(FUNC_DELETE, 16'h0000, '0, '0, '0, '0);
        push_op(FUNC_INSERT, 16'hFFFF, 10'h3FF, 10'h3FF, 7'h7F, 16'hFFFF);
        push_op(FUNC_INSERT, 16'h0000, 10'h000, 10'h000, 7'h00, 16'h0000);
        for (int i = 0; i < 14; i++) begin
            push_op(FUNC_INSERT, 16'(i % 5), 10'(i % 3), 10'(i * 37), 7'(i % 2),
                    16'(16'hA5A5 ^ i));
        end
        push_op(FUNC_INSERT, 16'h1234, 10'h001, 10'h155, 7'h2A, 16'h5555);
        push_op(FUNC_DELETE, 16'h0002, '0, '0, '0, '0);
        push_op(FUNC_DELETE, 16'h7777, '0, '0, '0, '0);
        push_op(FUNC_DELETE, 16'hFFFF, 10'h3FF, 10'h3FF, 7'h7F, 16'hFFFF);
        push_op(FUNC_INSERT, 16'hAAAA, 10'h000, 10'h2AA, 7'h7F, 16'hAAAA);

        ins_pct = 50;
        for (int n = 0; n < 1600; n++) begin
            if (n % 50 == 0)
                ins_pct = $urandom_range(85, 25);
            f     = ($urandom_range(99) < ins_pct) ? FUNC_INSERT : FUNC_DELETE;
            id    = ($urandom_range(99) < 80) ? ID_W'($urandom_range(31)) : ID_W'($urandom);
            kind  = ($urandom_range(99) < 60) ? KIND_W'($urandom_range(7)) : KIND_W'($urandom);
            wheel = ($urandom_range(99) < 50) ? WHEEL_W'($urandom_range(3)) : WHEEL_W'($urandom);
            push_op(f, id, kind, COLOR_W'($urandom), wheel, OWNER_W'($urandom));
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (pending_ops.size() != 0 || i_in_valid || outcome_q.size() != 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
src/srt_pkg.sv
src/srt_cell.sv
src/sorted_record_table.sv
tb/tb_top.sv
